/* rtl/core/swms_pkg.sv */
// ============================================================================
// swms_pkg: shared types and constants for the sliding window max sum block
// Result width, saturation limits, window register format and cell control.
// ============================================================================
`default_nettype none

package swms_pkg;

  // Running sum and result width
  localparam int TOTAL_W = 48;

  // Window length register
  localparam int LEN_W = 5;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

  // Saturation limits of the running sum
  localparam logic signed [TOTAL_W-1:0] SUM_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] SUM_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Control broadcast to every cell of the candidate row
  typedef struct packed {
    logic shift;  // a request was taken: every cell loads its younger neighbor (cell 0 the sample)
    logic clear;  // array finished: drop all candidates
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/swms_in_if.sv */
// ============================================================================
// swms_in_if: sample request channel
// Valid/ready channel carrying one signed sample and the end-of-array flag.
// ============================================================================
`default_nettype none

interface swms_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/swms_out_if.sv */
// ============================================================================
// swms_out_if: result request channel
// Valid/ready channel carrying the saturated sum and its overflow flag.
// ============================================================================
`default_nettype none

interface swms_out_if;
  import swms_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total;
  logic                      overflow;

  modport source (output valid, output total, output overflow, input ready);
  modport sink   (input valid, input total, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/swms_cfg_if.sv */
// ============================================================================
// swms_cfg_if: configuration write channel
// Valid/ready channel carrying the window length register write data.
// ============================================================================
`default_nettype none

interface swms_cfg_if;
  import swms_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

`default_nettype wire

/* rtl/core/swms_cell.sv */
// ============================================================================
// swms_cell: one slot of the candidate row
// Holds the sample of a fixed age and a flag telling whether it is still a
// candidate maximum. Hands a survivor bit and its value to the older neighbor.
// ============================================================================
`default_nettype none

module swms_cell
  import swms_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int KW          = 5,
  parameter int IDX         = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cell_ctrl_t                    ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic        [KW-1:0]          k,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_value,
  input  wire logic                          prev_flag,
  input  wire logic signed [SAMPLE_BITS-1:0] front_in,
  output logic signed [SAMPLE_BITS-1:0]      value,
  output logic                               survive,
  output logic signed [SAMPLE_BITS-1:0]      front_out
);

  localparam logic [KW-1:0] AGE = KW'(IDX + 1);

  logic flag;

  // Still inside the window ending at x and not dominated by x
  assign survive   = flag && (AGE < k) && (value > x);
  // Oldest flagged slot wins the front
  assign front_out = flag ? value : front_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.clear) begin
      flag <= 1'b0;
    end else if (ctrl.shift) begin
      flag <= prev_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= prev_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sliding_window_max_sum.sv */
// ============================================================================
// sliding_window_max_sum: sum of sliding window maxima over a sample stream
// Monotonic candidate queue kept as a row of aging cells, saturating sum.
// ============================================================================
// Samples arrive one request at a time on stream, the final one of an array
// marked by last. The block adds the maximum of every full window of
// window_len samples (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX)
// to a 48-bit sum that saturates and sets a sticky overflow flag. An array
// shorter than the window adds the maximum of all its samples once. On the
// final sample one result carries the sum and the flag, and all stream state
// is cleared; window_len keeps its value. Throughput is one sample per clock:
// the candidate row of WINDOW_MAX cells updates in the cycle a sample is
// taken, and the sum stage then adds the row's front once the sample is
// registered as pending. After a final sample, stream drops ready while the
// result is formed, and for longer if the previous result still waits on
// result. No clearing pass is needed after reset.
`default_nettype none

module sliding_window_max_sum
  import swms_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  swms_in_if.sink   stream,
  swms_out_if.source result,
  swms_cfg_if.sink  cfg
);

  // Ages run 1..WINDOW_MAX; window length compares need room for both.
  localparam int AGE_W = $clog2(WINDOW_MAX + 1);
  localparam int KW    = (AGE_W > LEN_W) ? AGE_W : LEN_W;

  // --------------------------------------------------------------------------
  // Window length register and its effective value
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] window_len;
  logic [KW-1:0]    k;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (cfg.valid) begin
      window_len <= cfg.window_len;
    end
  end

  always_comb begin
    if (window_len == '0) begin
      k = KW'(1);
    end else if (KW'(window_len) > KW'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_len);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and sum stage control
  // --------------------------------------------------------------------------
  logic accept;
  logic pend;       // a sample waits for its sum update
  logic pend_last;  // ... and it ends the array
  logic pend_acc;   // ... and its window maximum is added
  logic out_free;
  logic fire;       // sum stage completes this cycle

  assign out_free     = !result.valid || result.ready;
  assign fire         = pend && (!pend_last || out_free);
  // Hold off new samples until a finished array has left the sum stage
  assign stream.ready = !(pend && pend_last);
  assign accept       = stream.valid && stream.ready;

  // Samples seen in this array, saturating at WINDOW_MAX
  logic [AGE_W-1:0] seen;
  logic [AGE_W-1:0] seen_next;

  assign seen_next = (seen < AGE_W'(WINDOW_MAX)) ? seen + AGE_W'(1) : seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      pend_last <= 1'b0;
      pend_acc  <= 1'b0;
      seen      <= '0;
    end else begin
      if (accept) begin
        pend      <= 1'b1;
        pend_last <= stream.last;
        // full window reached, or a short array ends here
        pend_acc  <= (KW'(seen_next) >= k) || stream.last;
        seen      <= seen_next;
      end else if (fire) begin
        pend <= 1'b0;
        if (pend_last) begin
          seen <= '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Candidate row: cell j holds the sample of age j+1 after an update.
  // A cell's flag marks a live queue entry; the new sample always enters
  // flagged in cell 0, and an entry survives only while inside the window
  // and above every later sample. Flagged values fall from oldest to newest,
  // so the oldest flagged cell is the window maximum.
  // --------------------------------------------------------------------------
  cell_ctrl_t                    ctrl;
  logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
  logic                          cell_surv  [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] front      [WINDOW_MAX+1];

  assign ctrl.shift = accept;
  assign ctrl.clear = fire && pend_last;
  assign front[0]   = '0;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev_value;
    logic                          prev_flag;

    if (j == 0) begin : g_head
      assign prev_value = stream.sample;
      assign prev_flag  = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[j-1];
      assign prev_flag  = cell_surv[j-1];
    end

    swms_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .KW          (KW),
      .IDX         (j)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .x          (stream.sample),
      .k          (k),
      .prev_value (prev_value),
      .prev_flag  (prev_flag),
      .front_in   (front[j]),
      .value      (cell_value[j]),
      .survive    (cell_surv[j]),
      .front_out  (front[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Saturating running sum
  // --------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0] running_sum;
  logic                      sum_saturated;
  logic signed [TOTAL_W:0]   addend;
  logic signed [TOTAL_W:0]   sum_wide;
  logic                      sum_ovf;
  logic signed [TOTAL_W-1:0] sum_next;
  logic                      sat_next;

  assign addend   = pend_acc ? (TOTAL_W+1)'(front[WINDOW_MAX]) : '0;
  assign sum_wide = (TOTAL_W+1)'(running_sum) + addend;
  // top two bits disagree: result left the 48-bit range
  assign sum_ovf  = sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1];
  assign sat_next = sum_saturated || sum_ovf;

  always_comb begin
    if (!sum_ovf) begin
      sum_next = sum_wide[TOTAL_W-1:0];
    end else if (sum_wide[TOTAL_W]) begin
      sum_next = SUM_MIN;
    end else begin
      sum_next = SUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      sum_saturated <= 1'b0;
    end else if (fire) begin
      if (pend_last) begin
        running_sum   <= '0;
        sum_saturated <= 1'b0;
      end else begin
        running_sum   <= sum_next;
        sum_saturated <= sat_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire && pend_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pend_last) begin
      result.total    <= sum_next;
      result.overflow <= sat_next;
    end
  end

endmodule

`default_nettype wire
